### sv/word_sender_with_ack_retry_top_macros.svh
// Assertion macros used by the checker of this block.
`ifndef WORD_SENDER_WITH_ACK_RETRY_TOP_MACROS_SVH
`define WORD_SENDER_WITH_ACK_RETRY_TOP_MACROS_SVH

// Check prop on every rising edge of clk, idle while reset is held low.
`define WSA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that trig in one cycle is followed by resp in the next one.
`define WSA_ASSERT_NEXT(label, clk, rst_n, trig, resp, msg) \
  `WSA_ASSERT(label, clk, rst_n, (trig) |=> (resp), msg)

`endif

### sv/wsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsa_pkg;

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_DELIVERED = 2'd1,
    KIND_ABORTED   = 2'd2
  } kind_t;

  // Input command codes
  localparam logic CMD_SEND     = 1'b0;
  localparam logic CMD_RESPONSE = 1'b1;

  // Exchange state
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_AWAIT = 1'b1
  } st_t;

  localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd3;
  localparam logic [2:0] FRAME_LEN        = 3'd5;
  localparam logic [2:0] STATUS_LEN       = 3'd1;

  // Frame handed from the controller to the emitter on an accepted item
  typedef struct packed {
    logic        load;
    kind_t       kind;
    logic [31:0] word;
    logic [7:0]  sum;
  } frame_t;

endpackage

`default_nettype wire

### sv/wsa_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wsa_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] message;
  logic [7:0]  response;

  modport source (output valid, output cmd, output message, output response, input ready);
  modport sink (input valid, input cmd, input message, input response, output ready);
endinterface

`default_nettype wire

### sv/wsa_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wsa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, output kind, output tx_byte, output last, input ready);
  modport sink (input valid, input kind, input tx_byte, input last, output ready);
endinterface

`default_nettype wire

### sv/wsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wsa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [3:0]    cfg_data,
  input  wire logic          acc,
  input  wire logic          cmd,
  input  wire logic [31:0]   message,
  input  wire logic [7:0]    response,
  output wsa_pkg::frame_t    frame
);

  wsa_pkg::st_t st_r, st_nxt;
  logic [31:0]  held_word_r, held_word_nxt;
  logic [7:0]   held_sum_r, held_sum_nxt;
  logic [3:0]   tries_r, tries_nxt;
  logic [3:0]   max_att_r;
  logic [7:0]   msg_sum;

  // Sum the four message bytes modulo 256
  assign msg_sum = message[31:24] + message[23:16] + message[15:8] + message[7:0];

  // Next state of the exchange
  always_comb begin
    st_nxt = st_r;
    if (acc) begin
      unique case (st_r)
        wsa_pkg::ST_IDLE: begin
          if (cmd == wsa_pkg::CMD_SEND) st_nxt = wsa_pkg::ST_AWAIT;
        end
        wsa_pkg::ST_AWAIT: begin
          if (cmd == wsa_pkg::CMD_RESPONSE &&
              (response[7] || !(tries_r < max_att_r))) begin
            st_nxt = wsa_pkg::ST_IDLE;
          end
        end
        default: st_nxt = wsa_pkg::ST_IDLE;
      endcase
    end
  end

  // Frame to emit and held data updates
  always_comb begin
    frame         = '0;
    frame.kind    = wsa_pkg::KIND_BYTE;
    frame.word    = held_word_r;
    frame.sum     = held_sum_r;
    held_word_nxt = held_word_r;
    held_sum_nxt  = held_sum_r;
    tries_nxt     = tries_r;
    if (acc) begin
      unique case (st_r)
        wsa_pkg::ST_IDLE: begin
          if (cmd == wsa_pkg::CMD_SEND) begin
            frame.load    = 1'b1;
            frame.word    = message;
            frame.sum     = msg_sum;
            held_word_nxt = message;
            held_sum_nxt  = msg_sum;
            tries_nxt     = 4'd1;
          end
        end
        wsa_pkg::ST_AWAIT: begin
          if (cmd == wsa_pkg::CMD_RESPONSE) begin
            frame.load = 1'b1;
            if (response[7]) begin
              frame.kind = wsa_pkg::KIND_DELIVERED;
            end else if (tries_r < max_att_r) begin
              tries_nxt = tries_r + 4'd1;
            end else begin
              frame.kind = wsa_pkg::KIND_ABORTED;
            end
          end
        end
        default: frame.load = 1'b0;
      endcase
    end
  end

  // Hold exchange state and the attempt limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= wsa_pkg::ST_IDLE;
      held_word_r <= '0;
      held_sum_r  <= '0;
      tries_r     <= '0;
      max_att_r   <= wsa_pkg::MAX_ATTEMPTS_RST;
    end else begin
      st_r        <= st_nxt;
      held_word_r <= held_word_nxt;
      held_sum_r  <= held_sum_nxt;
      tries_r     <= tries_nxt;
      if (cfg_we) max_att_r <= cfg_data;
    end
  end

endmodule

`default_nettype wire

### sv/wsa_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module wsa_emit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire wsa_pkg::frame_t frame,
  output logic               free,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_tx_byte,
  output logic               out_last
);

  logic [2:0]     cnt_r, cnt_nxt;
  wsa_pkg::kind_t kind_r;
  logic [31:0]    word_r;
  logic [7:0]     sum_r;
  logic           xfer;

  assign out_valid = (cnt_r != 3'd0);
  assign xfer      = out_valid && out_ready;
  // Take a new item once the final result of the current one is leaving
  assign free      = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ready);

  // Load the result count for a new frame, else count down the results left in the frame
  always_comb begin
    cnt_nxt = cnt_r;
    if (frame.load) begin
      cnt_nxt = (frame.kind == wsa_pkg::KIND_BYTE) ? wsa_pkg::FRAME_LEN : wsa_pkg::STATUS_LEN;
    end else if (xfer) begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Latch the frame payload
  always_ff @(posedge clk) begin
    if (frame.load) begin
      kind_r <= frame.kind;
      word_r <= frame.word;
      sum_r  <= frame.sum;
    end
  end

  // Pick the byte for the current position, most significant first
  always_comb begin
    out_kind    = kind_r;
    out_last    = (cnt_r == 3'd1);
    out_tx_byte = '0;
    if (kind_r == wsa_pkg::KIND_BYTE) begin
      case (cnt_r)
        3'd5:    out_tx_byte = word_r[31:24];
        3'd4:    out_tx_byte = word_r[23:16];
        3'd3:    out_tx_byte = word_r[15:8];
        3'd2:    out_tx_byte = word_r[7:0];
        default: out_tx_byte = sum_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/word_sender_with_ack_retry_top.sv
// The first result of an item is offered in the cycle after the item transfer.
// A send or resend gives five bytes, one per cycle while out_ch.ready is high, so the
// next item is taken at the earliest in the cycle its fifth byte transfers; a delivered
// or aborted item gives one status result. The result counter sets the pace.
// Reset (rst_n low, synchronous): idle, held word, checksum and try count cleared,
// max_attempts back to 3, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module word_sender_with_ack_retry_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   cfg_we,
  input  wire logic [3:0] cfg_data,
  wsa_in_if.sink      in_ch,
  wsa_out_if.source   out_ch
);

  wsa_pkg::frame_t frame;
  logic            free;
  logic            acc;

  // Input transfer
  assign in_ch.ready = free;
  assign acc         = in_ch.valid && free;

  wsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .acc      (acc),
    .cmd      (in_ch.cmd),
    .message  (in_ch.message),
    .response (in_ch.response),
    .frame    (frame)
  );

  wsa_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame       (frame),
    .free        (free),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.kind),
    .out_tx_byte (out_ch.tx_byte),
    .out_last    (out_ch.last)
  );

endmodule

`default_nettype wire

### sv/wsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "word_sender_with_ack_retry_top_macros.svh"

module wsa_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_tx_byte,
  input wire logic       out_last
);

  // Stalled result holds its payload
  `WSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_tx_byte) && $stable(out_last), "stalled result changed")

  // Status results are single, final and carry no byte
  `WSA_ASSERT(a_status_form, clk, rst_n, out_valid && out_kind != wsa_pkg::KIND_BYTE |-> out_last && out_tx_byte == 8'd0, "malformed status result")

  // No new item while a frame is still mid-way
  `WSA_ASSERT(a_no_accept_mid, clk, rst_n, out_valid && !out_last |-> !(in_valid && in_ready), "input taken inside a frame")

  // A non-final byte is followed at once by another byte
  `WSA_ASSERT_NEXT(a_frame_cont, clk, rst_n, out_valid && out_ready && !out_last, out_valid && out_kind == wsa_pkg::KIND_BYTE, "frame broken off")

endmodule

bind word_sender_with_ack_retry_top wsa_checker u_wsa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.kind),
  .out_tx_byte (out_ch.tx_byte),
  .out_last    (out_ch.last)
);

`default_nettype wire
